[rtl/opp_pkg.sv]
// Shared types, constants and helper functions for the orbit phase/position generator.
// No dependencies; opp_cordic and the top level import this package.
package opp_pkg;

  // Internal CORDIC datapath width (Q2.30 values plus headroom)
  localparam int CW = 34;

  localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30      = 34'sd1073741824;
  localparam logic signed [CW-1:0] NEG_ONE_Q30  = -34'sd1073741824;
  localparam logic signed [33:0]   POS_MAX      = 34'sd65535;
  localparam logic signed [33:0]   NEG_POS_MAX  = -34'sd65535;

  // Configuration register indexes
  localparam logic [7:0] REG_ORBIT_SPEED  = 8'd0;
  localparam logic [7:0] REG_ORBIT_RADIUS = 8'd1;
  localparam logic [7:0] REG_PHASE_OFFSET = 8'd2;
  localparam logic [7:0] REG_TILT_ANGLE   = 8'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP_MUL,
    ST_ACC,
    ST_ANG,
    ST_CORD_A,
    ST_CORD_T,
    ST_MUL_SS,
    ST_MUL_SC,
    ST_MUL_RC,
    ST_MUL_R1,
    ST_MUL_R2,
    ST_OUT
  } opp_state_t;

  // CORDIC result bundle
  typedef struct packed {
    logic               done;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } cordic_res_t;

  // Arctangent of 2^-i in 2^-32 turn units
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Shift a Q2.30 x Q2.30 (or Q8.8 x Q2.30) product right by 30, nearest, ties up
  function automatic logic signed [33:0] rnd30(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = v + 64'sd536870912;
    return $signed(s[63:30]);
  endfunction

  // Saturate a position to the Q8.8 output range
  function automatic logic signed [16:0] sat_pos(input logic signed [33:0] v);
    logic signed [16:0] r;
    if (v > POS_MAX) begin
      r = 17'sd65535;
    end else if (v < NEG_POS_MAX) begin
      r = -17'sd65535;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

endpackage

[rtl/opp_mul.sv]
// Shared signed 32x32 multiplier with a registered 64-bit product.
// No package dependencies; used by the top-level sequencer.
module opp_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);

  logic signed [63:0] prod_r;
  logic signed [63:0] prod_nxt;

  // Product is captured only on issue cycles so it holds while the sequencer waits
  always_comb begin
    prod_nxt = prod_r;
    if (en) begin
      prod_nxt = a * b;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

[rtl/opp_cordic.sv]
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, cos/sin in Q2.30.
// Depends on opp_pkg (atan table, constants, result struct).
module opp_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [15:0]         angle,
  output opp_pkg::cordic_res_t res
);
  import opp_pkg::*;

  localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

  logic signed [CW-1:0] x_r, x_nxt;
  logic signed [CW-1:0] y_r, y_nxt;
  logic signed [CW-1:0] z_r, z_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 flip_r, flip_nxt;

  logic [31:0]          u;
  logic                 flip_in;
  logic signed [CW-1:0] at_v;
  logic signed [CW-1:0] xf, yf;

  // Load, fold into the right half plane, then iterate
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    flip_nxt = flip_r;
    u        = {angle, 16'h0000};
    flip_in  = u[31] ^ u[30];
    at_v     = $signed(CW'(atan_turn(5'(cnt_r))));
    if (start) begin
      // Angles in the left half plane move by half a turn; results get negated
      x_nxt    = INV_GAIN_Q30;
      y_nxt    = '0;
      z_nxt    = CW'($signed({u[31] ^ flip_in, u[30:0]}));
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      flip_nxt = flip_in;
    end else if (busy_r) begin
      if (!z_r[CW-1]) begin
        x_nxt = x_r - (y_r >>> cnt_r);
        y_nxt = y_r + (x_r >>> cnt_r);
        z_nxt = z_r - at_v;
      end else begin
        x_nxt = x_r + (y_r >>> cnt_r);
        y_nxt = y_r - (x_r >>> cnt_r);
        z_nxt = z_r + at_v;
      end
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    cnt_r  <= cnt_nxt;
    flip_r <= flip_nxt;
  end

  // Undo the fold and clamp to [-1, 1]
  always_comb begin
    xf = flip_r ? -x_r : x_r;
    yf = flip_r ? -y_r : y_r;
    if (xf > ONE_Q30) begin
      xf = ONE_Q30;
    end else if (xf < NEG_ONE_Q30) begin
      xf = NEG_ONE_Q30;
    end
    if (yf > ONE_Q30) begin
      yf = ONE_Q30;
    end else if (yf < NEG_ONE_Q30) begin
      yf = NEG_ONE_Q30;
    end
    res.done  = done_r;
    res.cos_v = xf[31:0];
    res.sin_v = yf[31:0];
  end

endmodule

[rtl/orbit_phase_position_generator_core.sv]
// Top level: config registers, phase accumulator, sequencer and output register.
// Depends on opp_pkg, opp_mul and opp_cordic.
//
// Usage:
//   Input channel (in_valid / in_stall / in_time_step): one item per time step.
//   in_stall is high whenever an item is in progress; the block takes one item
//   at a time.
//   Result channel (out_valid / out_stall / out_*): one result item per input
//   item, held in an output register so the next input item can be taken while
//   a result still waits. The result register holds its value while out_stall
//   is high; a finished item waits in the last sequencer state if the output
//   register is still full.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_wdata): always
//   ready; indexes 0..3 write speed, radius, phase offset and tilt, others are
//   dropped. Write only while no item is in progress.
//   The shared CORDIC unit runs twice per item (orbit angle, then tilt angle)
//   at one micro-rotation per cycle, and one shared 32x32 multiplier does the
//   six products in turn.
//   Reset (rst_n low, synchronous) clears the phase accumulator, sets radius
//   to 1.0, speed, offset and tilt to 0, and empties the output register.
module orbit_phase_position_generator_core #(
  parameter int PHASE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_time_step,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_phase_now,
  output logic signed [16:0] out_pos_x,
  output logic signed [16:0] out_pos_y,
  output logic signed [16:0] out_pos_z,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import opp_pkg::*;

  localparam int SH = 32 - PHASE_BITS;
  localparam logic [40:0] RND_HALF = (41'd1 << SH) >> 1;

  // Config registers
  logic signed [23:0] speed_r;
  logic [15:0]        radius_r;
  logic [15:0]        offset_r;
  logic [15:0]        tilt_r;

  // Control
  opp_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Datapath registers
  logic [PHASE_BITS-1:0] acc_r, acc_nxt;
  logic [15:0]           dt_r, dt_nxt;
  logic [15:0]           ph16_r, ph16_nxt;
  logic signed [31:0]    ca_r, ca_nxt, sa_r, sa_nxt;
  logic signed [31:0]    ct_r, ct_nxt, st_r, st_nxt;
  logic signed [31:0]    t1_r, t1_nxt, t2_r, t2_nxt;
  logic signed [16:0]    px_r, px_nxt, py_r, py_nxt;
  logic [15:0]           o_ph_r, o_ph_nxt;
  logic signed [16:0]    o_x_r, o_x_nxt, o_y_r, o_y_nxt, o_z_r, o_z_nxt;

  // Shared-unit hookups
  logic               mul_en;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic               cor_start;
  logic [15:0]        cor_angle;
  cordic_res_t        cor_res;

  // Combinational helpers
  logic signed [40:0]    p_rnd;
  logic signed [40:0]    p_sh;
  logic [31:0]           acc_wide;
  logic [15:0]           ph16_now;
  logic signed [31:0]    radius_s;
  logic                  out_free;

  opp_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  opp_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_angle),
    .res   (cor_res)
  );

  // Configuration writes, always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r  <= '0;
      radius_r <= 16'd256;
      offset_r <= '0;
      tilt_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORBIT_SPEED:  speed_r  <= $signed(cfg_wdata[23:0]);
        REG_ORBIT_RADIUS: radius_r <= cfg_wdata[15:0];
        REG_PHASE_OFFSET: offset_r <= cfg_wdata[15:0];
        REG_TILT_ANGLE:   tilt_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Phase step rounding and phase alignment to Q0.16
  always_comb begin
    p_rnd    = $signed(prod[40:0]) + $signed(RND_HALF);
    p_sh     = p_rnd >>> SH;
    acc_wide = 32'(acc_r) << SH;
    ph16_now = acc_wide[31:16];
    radius_s = $signed({16'h0000, radius_r});
    out_free = !out_valid_r || !out_stall;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    acc_nxt       = acc_r;
    dt_nxt        = dt_r;
    ph16_nxt      = ph16_r;
    ca_nxt        = ca_r;
    sa_nxt        = sa_r;
    ct_nxt        = ct_r;
    st_nxt        = st_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    o_ph_nxt      = o_ph_r;
    o_x_nxt       = o_x_r;
    o_y_nxt       = o_y_r;
    o_z_nxt       = o_z_r;
    mul_en        = 1'b0;
    mul_a         = 32'(speed_r);
    mul_b         = $signed({16'h0000, dt_r});
    cor_start     = 1'b0;
    cor_angle     = ph16_now + offset_r;
    in_stall      = (state_r != ST_IDLE);

    // Result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          dt_nxt    = in_time_step;
          state_nxt = ST_STEP_MUL;
        end
      end
      ST_STEP_MUL: begin
        // speed * time_step
        mul_en    = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt   = acc_r + p_sh[PHASE_BITS-1:0];
        state_nxt = ST_ANG;
      end
      ST_ANG: begin
        ph16_nxt  = ph16_now;
        cor_start = 1'b1;
        state_nxt = ST_CORD_A;
      end
      ST_CORD_A: begin
        cor_angle = tilt_r;
        if (cor_res.done) begin
          ca_nxt    = cor_res.cos_v;
          sa_nxt    = cor_res.sin_v;
          cor_start = 1'b1;
          state_nxt = ST_CORD_T;
        end
      end
      ST_CORD_T: begin
        if (cor_res.done) begin
          ct_nxt    = cor_res.cos_v;
          st_nxt    = cor_res.sin_v;
          state_nxt = ST_MUL_SS;
        end
      end
      ST_MUL_SS: begin
        mul_en    = 1'b1;
        mul_a     = sa_r;
        mul_b     = st_r;
        state_nxt = ST_MUL_SC;
      end
      ST_MUL_SC: begin
        mul_en    = 1'b1;
        mul_a     = sa_r;
        mul_b     = ct_r;
        t1_nxt    = 32'(rnd30(prod));
        state_nxt = ST_MUL_RC;
      end
      ST_MUL_RC: begin
        mul_en    = 1'b1;
        mul_a     = radius_s;
        mul_b     = ca_r;
        t2_nxt    = 32'(rnd30(prod));
        state_nxt = ST_MUL_R1;
      end
      ST_MUL_R1: begin
        mul_en    = 1'b1;
        mul_a     = radius_s;
        mul_b     = t1_r;
        px_nxt    = sat_pos(rnd30(prod));
        state_nxt = ST_MUL_R2;
      end
      ST_MUL_R2: begin
        mul_en    = 1'b1;
        mul_a     = radius_s;
        mul_b     = t2_r;
        py_nxt    = sat_pos(-rnd30(prod));
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // Hand the item to the output register once it is free
        if (out_free) begin
          o_ph_nxt      = ph16_r;
          o_x_nxt       = px_r;
          o_y_nxt       = py_r;
          o_z_nxt       = sat_pos(rnd30(prod));
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dt_r   <= dt_nxt;
    ph16_r <= ph16_nxt;
    ca_r   <= ca_nxt;
    sa_r   <= sa_nxt;
    ct_r   <= ct_nxt;
    st_r   <= st_nxt;
    t1_r   <= t1_nxt;
    t2_r   <= t2_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    o_ph_r <= o_ph_nxt;
    o_x_r  <= o_x_nxt;
    o_y_r  <= o_y_nxt;
    o_z_r  <= o_z_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_phase_now = o_ph_r;
  assign out_pos_x     = o_x_r;
  assign out_pos_y     = o_y_r;
  assign out_pos_z     = o_z_r;

endmodule

[tb/sv/orbit_position_checker.sv]
// Checker for orbit_phase_position_generator_core: follows register writes, predicts the
// phase and tilted-orbit position of every accepted time step and compares result items.
// Depends on opp_pkg for the register index constants.
module orbit_position_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [15:0]        in_time_step,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        out_phase_now,
  input  logic signed [16:0] out_pos_x,
  input  logic signed [16:0] out_pos_y,
  input  logic signed [16:0] out_pos_z,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import opp_pkg::*;

  localparam int     ROTATIONS    = 16;
  localparam longint UNIT_Q30     = 64'sd1073741824;
  localparam longint QUARTER_TURN = 64'sd1073741824;   // 2^30 in 2^-32 turn units
  localparam longint HALF_TURN    = 64'sd2147483648;
  localparam longint START_X      = 64'sd652032874;    // 1/gain, Q2.30
  localparam longint POS_LIMIT    = 64'sd65535;
  localparam longint ATAN_TURN32 [ROTATIONS] = '{
    536870912, 316933406, 167458907, 85004756,
    42667331, 21354465, 10679838, 5340245,
    2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  typedef struct packed {
    logic [15:0]        phase;
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic signed [16:0] z;
  } orbit_pos_t;

  logic [23:0] speed_q;
  logic [15:0] radius_q;
  logic [15:0] offset_q;
  logic [15:0] tilt_q;
  logic [15:0] phase_acc;
  orbit_pos_t  expected_pos_q[$];

  // shift right by 30, nearest, ties up
  function automatic longint round_q30(input longint v);
    return (v + (UNIT_Q30 >>> 1)) >>> 30;
  endfunction

  function automatic longint clip(input longint v, input longint lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  // cosine and sine of a Q0.16 turn, Q2.30
  function automatic void cordic_cos_sin(input logic [15:0] ang, output longint c,
                                         output longint s);
    int     ang32;
    int     i;
    longint z;
    longint cx;
    longint sy;
    longint nx;
    bit     flip;
    ang32 = {ang, 16'h0000};
    z     = longint'(ang32);
    cx    = START_X;
    sy    = 0;
    flip  = 1'b0;
    // the half turn around one half is rotated by a half turn, result negated
    if (z >= QUARTER_TURN || z < -QUARTER_TURN) begin
      z    = (z >= 0) ? z - HALF_TURN : z + HALF_TURN;
      flip = 1'b1;
    end
    for (i = 0; i < ROTATIONS; i++) begin
      if (z >= 0) begin
        nx = cx - (sy >>> i);
        sy = sy + (cx >>> i);
        z  = z - ATAN_TURN32[i];
      end else begin
        nx = cx + (sy >>> i);
        sy = sy - (cx >>> i);
        z  = z + ATAN_TURN32[i];
      end
      cx = nx;
    end
    if (flip) begin
      cx = -cx;
      sy = -sy;
    end
    c = clip(cx, UNIT_Q30);
    s = clip(sy, UNIT_Q30);
  endfunction

  // advance the phase by one time step and work out the tilted position
  function automatic orbit_pos_t advance_orbit(input logic [15:0] dt);
    orbit_pos_t res;
    longint     spd;
    longint     prod;
    longint     step;
    longint     r;
    longint     ca;
    longint     sa;
    longint     ct;
    longint     st;
    spd       = longint'($signed(speed_q));
    prod      = spd * longint'(dt);
    step      = (prod + 32768) >>> 16;   // nearest, ties toward +inf
    phase_acc = phase_acc + step[15:0];
    r         = longint'(radius_q);
    cordic_cos_sin(phase_acc + offset_q, ca, sa);
    cordic_cos_sin(tilt_q, ct, st);
    res.phase = phase_acc;
    res.x     = 17'(clip(round_q30(r * ca), POS_LIMIT));
    res.y     = 17'(clip(-round_q30(r * round_q30(sa * st)), POS_LIMIT));
    res.z     = 17'(clip(round_q30(r * round_q30(sa * ct)), POS_LIMIT));
    return res;
  endfunction

  function automatic int field_differs(input string name, input longint want,
                                       input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    orbit_pos_t got;
    orbit_pos_t want;
    if (!rst_n) begin
      speed_q   = '0;
      radius_q  = 16'd256;
      offset_q  = '0;
      tilt_q    = '0;
      phase_acc = '0;
      expected_pos_q.delete();
    end else begin
      // register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ORBIT_SPEED:  speed_q  = cfg_wdata[23:0];
          REG_ORBIT_RADIUS: radius_q = cfg_wdata[15:0];
          REG_PHASE_OFFSET: offset_q = cfg_wdata[15:0];
          REG_TILT_ANGLE:   tilt_q   = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_pos_q.push_back(advance_orbit(in_time_step));
      end
      // compare each result item with the oldest prediction
      if (out_valid && !out_stall) begin
        got = '{out_phase_now, out_pos_x, out_pos_y, out_pos_z};
        if (expected_pos_q.size() == 0) begin
          $display("%0t: result item with nothing expected, expected none, got %h",
                   $time, got);
          fail_count = fail_count + 1;
        end else begin
          want       = expected_pos_q.pop_front();
          fail_count = fail_count
                     + field_differs("phase_now", longint'(want.phase), longint'(got.phase))
                     + field_differs("pos_x", longint'(want.x), longint'(got.x))
                     + field_differs("pos_y", longint'(want.y), longint'(got.y))
                     + field_differs("pos_z", longint'(want.z), longint'(got.z));
        end
      end
    end
    pending <= expected_pos_q.size();
  end

endmodule

[tb/sv/orbit_phase_position_generator_core_tb.sv]
// Top of the orbit phase/position generator testbench: clock, reset, register setup,
// time step stimulus, result stall pattern, watchdog and verdict.
// Depends on opp_pkg, orbit_position_checker and the block's RTL.
module orbit_phase_position_generator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT     = 2000;
  localparam int TAIL_CYCLES     = 60;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 100;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic [15:0]        in_time_step = '0;
  logic               out_stall    = 1'b0;
  logic               cfg_valid    = 1'b0;
  logic [7:0]         cfg_index    = '0;
  logic [31:0]        cfg_wdata    = '0;
  logic               in_stall;
  logic               out_valid;
  logic [15:0]        out_phase_now;
  logic signed [16:0] out_pos_x;
  logic signed [16:0] out_pos_y;
  logic signed [16:0] out_pos_z;
  logic               cfg_ready;
  int                 fail_count;
  int                 pending;
  int                 quiet_cycles = 0;
  int                 burst_left   = 0;
  int                 stall_seg    = 0;
  stall_mode_t        stall_mode   = STALL_NONE;

  orbit_phase_position_generator_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_time_step (in_time_step),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_phase_now(out_phase_now),
    .out_pos_x    (out_pos_x),
    .out_pos_y    (out_pos_y),
    .out_pos_z    (out_pos_z),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  orbit_position_checker orbit_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_time_step (in_time_step),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_phase_now(out_phase_now),
    .out_pos_x    (out_pos_x),
    .out_pos_y    (out_pos_y),
    .out_pos_z    (out_pos_z),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one time step item; bursts of random length with random gaps between them
  task automatic send_step(input logic [15:0] dt);
    int gap;
    in_valid     <= 1'b1;
    in_time_step <= dt;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold off until every predicted result item has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // all four registers, optionally preceded by a write to an unused index
  task automatic program_orbit(input logic [31:0] spd, input logic [31:0] rad,
                               input logic [31:0] off, input logic [31:0] tlt,
                               input bit stray);
    if (stray) begin
      write_reg(opp_pkg::REG_TILT_ANGLE + 8'($urandom_range(1, 252)), $urandom);
    end
    write_reg(opp_pkg::REG_ORBIT_SPEED, spd);
    write_reg(opp_pkg::REG_ORBIT_RADIUS, rad);
    write_reg(opp_pkg::REG_PHASE_OFFSET, off);
    write_reg(opp_pkg::REG_TILT_ANGLE, tlt);
    cfg_valid <= 1'b0;
  endtask

  // quadrant corners, the last angle, or anything with junk upper bits
  function automatic logic [31:0] pick_angle();
    case ($urandom_range(0, 3))
      0:       return 32'($urandom_range(0, 4)) << 14;
      1:       return 32'h0000_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // result side stall pattern
  always @(posedge clk) begin
    if (stall_seg == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_seg  = $urandom_range(20, 300);
    end
    stall_seg--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
      default:     out_stall <= (stall_seg % 29) < 13;
    endcase
  end

  // watchdog: too long without any item moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] spd_w;
    logic [31:0] rad_w;
    logic [15:0] dt;
    int          ph;
    int          n;
    int          k;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: no motion, unit radius
    send_step(16'h0000);
    send_step(16'hFFFF);
    wait_results_drained();

    // fastest forward spin, largest radius
    program_orbit(32'h007F_FFFF, 32'h0000_FFFF, 32'd0, 32'd0, 1'b0);
    send_step(16'hFFFF);
    send_step(16'h0001);
    send_step(16'h0000);
    send_step(16'h8000);
    wait_results_drained();

    // fastest reverse spin, zero radius, last offset and tilt
    program_orbit(32'h0080_0000, 32'd0, 32'h0000_FFFF, 32'h0000_FFFF, 1'b1);
    send_step(16'hFFFF);
    send_step(16'd12345);
    send_step(16'h0001);
    wait_results_drained();

    // rounding of half steps going backward, tilt a quarter turn
    program_orbit(32'h00FF_FFFF, 32'd256, 32'h0000_8000, 32'h0000_4000, 1'b0);
    send_step(16'h8000);
    send_step(16'h0001);
    send_step(16'hFFFF);
    wait_results_drained();

    // junk above the register widths; half steps going forward
    program_orbit(32'hFF00_0001, 32'hABCD_0100, 32'hFFFF_0000, 32'h1234_2000, 1'b1);
    send_step(16'h8000);
    send_step(16'h7FFF);
    wait_results_drained();

    // one phase unit per time unit: walk across every quadrant edge and the wrap
    program_orbit(32'h0001_0000, 32'd256, 32'd0, 32'h0000_C000, 1'b0);
    for (k = 0; k < 4; k++) begin
      send_step(16'h3FFF);
      send_step(16'h0001);
    end
    wait_results_drained();

    // random settings and time steps
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0:       spd_w = 32'h007F_FFFF;
        1:       spd_w = 32'h0080_0000;
        2:       spd_w = $urandom_range(0, 2000) - 1000;
        default: spd_w = $urandom;
      endcase
      case ($urandom_range(0, 4))
        0:       rad_w = 32'd0;
        1:       rad_w = 32'h0000_FFFF;
        2:       rad_w = 32'd256;
        default: rad_w = $urandom;
      endcase
      program_orbit(spd_w, rad_w, pick_angle(), pick_angle(), $urandom_range(0, 2) == 0);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(0, 9))
          0, 1:    dt = 16'($urandom_range(0, 255));
          2:       dt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          3:       dt = 16'h0001 << $urandom_range(0, 15);
          default: dt = 16'($urandom_range(0, 65535));
        endcase
        send_step(dt);
      end
      wait_results_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
